[src/mtwp_pkg.sv]
// Shared constants, codes and control structs for the map tile window planner.
// No dependencies; every other file imports this package.
`default_nettype none
package mtwp_pkg;

  localparam int VIEW_WIDTH  = 320;
  localparam int VIEW_HEIGHT = 240;
  localparam int TILE_EDGE   = 256;
  localparam int STORE_SLOTS = 8;
  localparam int MAX_ZOOM    = 20;

  localparam int TILE_SHIFT = $clog2(TILE_EDGE);
  localparam int MODE_W     = 2;
  localparam int ZOOM_W     = 5;
  localparam int ORG_W      = 26;
  localparam int SLOT_W     = 3;
  localparam int TILE_W     = 20;
  localparam int SX_W       = 10;
  localparam int SY_W       = 9;
  localparam int SRC_W      = 9;
  localparam int ST_W       = 2;

  localparam int TI_W     = ORG_W - TILE_SHIFT + 1;
  localparam int DX_W     = SX_W + 1;
  localparam int DY_W     = SY_W + 1;
  localparam int MAX_COLS = (VIEW_WIDTH + TILE_EDGE - 2) / TILE_EDGE + 1;
  localparam int MAX_ROWS = (VIEW_HEIGHT + TILE_EDGE - 2) / TILE_EDGE + 1;
  localparam int CIDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAN  = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [ST_W-1:0] {
    LK_HIT  = 2'd0,
    LK_MISS = 2'd1,
    LK_PEND = 2'd2
  } lk_status_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic fill;
    logic clear;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_plan;
    logic is_fill;
    logic is_clear;
    logic has_tile;
    logic last;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic              lookup;
    logic              fill;
    logic              clear;
    logic [SLOT_W-1:0] fill_slot;
    logic              fill_ok;
    logic [ZOOM_W-1:0] zoom;
    logic [TILE_W-1:0] col;
    logic [TILE_W-1:0] row;
  } tag_req_t;

endpackage
`default_nettype wire

[src/mtwp_tags.sv]
// Tile tag store: key registers, valid/pending bits and round-robin replace pointer.
// Depends on mtwp_pkg.
`default_nettype none
module mtwp_tags (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mtwp_pkg::tag_req_t     req,
  output logic [mtwp_pkg::ST_W-1:0]   status,
  output logic [mtwp_pkg::SLOT_W-1:0] slot
);
  import mtwp_pkg::*;

  logic [ZOOM_W-1:0]      key_zoom [STORE_SLOTS];
  logic [TILE_W-1:0]      key_col  [STORE_SLOTS];
  logic [TILE_W-1:0]      key_row  [STORE_SLOTS];
  logic [STORE_SLOTS-1:0] valid;
  logic [STORE_SLOTS-1:0] pending;
  logic [SLOT_W-1:0]      ptr;
  logic [SLOT_W-1:0]      ptr_next;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = STORE_SLOTS - 1; i >= 0; i--) begin
      if ((valid[i] || pending[i]) && key_zoom[i] == req.zoom &&
          key_col[i] == req.col && key_row[i] == req.row) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (!hit) begin
      status = LK_MISS;
    end else if (valid[hit_idx]) begin
      status = LK_HIT;
    end else begin
      status = LK_PEND;
    end
    slot     = hit ? hit_idx : ptr;
    ptr_next = (ptr == SLOT_W'(STORE_SLOTS - 1)) ? '0 : ptr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (req.lookup && !hit) begin
      key_zoom[ptr] <= req.zoom;
      key_col[ptr]  <= req.col;
      key_row[ptr]  <= req.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      pending <= '0;
      ptr     <= '0;
    end else if (req.clear) begin
      valid   <= '0;
      pending <= '0;
    end else if (req.fill) begin
      if (pending[req.fill_slot]) begin
        pending[req.fill_slot] <= 1'b0;
        valid[req.fill_slot]   <= req.fill_ok;
      end
    end else if (req.lookup && !hit) begin
      valid[ptr]   <= 1'b0;
      pending[ptr] <= 1'b1;
      ptr          <= ptr_next;
    end
  end

endmodule
`default_nettype wire

[src/mtwp_dp.sv]
// Datapath: item registers, tile range setup, tile walk, clip math and output register.
// Depends on mtwp_pkg and mtwp_tags.
`default_nettype none
module mtwp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mtwp_pkg::ctrl_cmd_t           cmd,
  output mtwp_pkg::dp_sts_t                  sts,
  input  wire logic [mtwp_pkg::MODE_W-1:0]   mode,
  input  wire logic [mtwp_pkg::ZOOM_W-1:0]   zoom,
  input  wire logic signed [mtwp_pkg::ORG_W-1:0] view_origin_x,
  input  wire logic signed [mtwp_pkg::ORG_W-1:0] view_origin_y,
  input  wire logic [mtwp_pkg::SLOT_W-1:0]   fill_slot,
  input  wire logic                          fill_ok,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mtwp_pkg::TILE_W-1:0]        tile_col,
  output logic [mtwp_pkg::TILE_W-1:0]        tile_row,
  output logic signed [mtwp_pkg::SX_W-1:0]   screen_x,
  output logic signed [mtwp_pkg::SY_W-1:0]   screen_y,
  output logic [mtwp_pkg::SRC_W-1:0]         src_x_begin,
  output logic [mtwp_pkg::SRC_W-1:0]         src_y_begin,
  output logic [mtwp_pkg::SRC_W-1:0]         src_x_end,
  output logic [mtwp_pkg::SRC_W-1:0]         src_y_end,
  output logic [mtwp_pkg::ST_W-1:0]          lookup_status,
  output logic [mtwp_pkg::SLOT_W-1:0]        slot,
  output logic                               last_tile
);
  import mtwp_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [ZOOM_W-1:0] zoom_r;
  logic [ORG_W-1:0]  vx_r;
  logic [ORG_W-1:0]  vy_r;
  logic [SLOT_W-1:0] fslot_r;
  logic              fok_r;

  logic [ORG_W:0]         xe;
  logic [ORG_W:0]         ye;
  logic [TI_W-1:0]        tx0_w;
  logic [TI_W-1:0]        tx1_w;
  logic [TI_W-1:0]        ty0_w;
  logic [TI_W-1:0]        ty1_w;
  logic [TILE_W-1:0]      mask_w;
  logic signed [TILE_W:0] ty0_s;
  logic signed [TILE_W:0] ty1_s;
  logic signed [TILE_W:0] mask_s;
  logic signed [TILE_W:0] row_first;
  logic signed [TILE_W:0] row_last;

  logic [TILE_W-1:0] tx0_q;
  logic [TILE_W-1:0] mask_q;
  logic [TILE_W-1:0] row_q;
  logic [TILE_W-1:0] row_end_q;
  logic [RIDX_W-1:0] roff_q;
  logic [CIDX_W-1:0] coff_q;
  logic [CIDX_W-1:0] ncol_m1_q;
  logic [TILE_SHIFT-1:0] xoff_q;
  logic [TILE_SHIFT-1:0] yoff_q;

  logic [TILE_W-1:0] col_w;
  logic [DX_W-1:0]   dx;
  logic [DY_W-1:0]   dy;
  logic [SRC_W-1:0]  sxb;
  logic [SRC_W-1:0]  sxe;
  logic [SRC_W-1:0]  syb;
  logic [SRC_W-1:0]  sye;
  logic              last_w;
  logic              col_wrap;
  tag_req_t          req;
  logic [ST_W-1:0]   tag_status;
  logic [SLOT_W-1:0] tag_slot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode;
      zoom_r  <= (zoom > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom;
      vx_r    <= view_origin_x;
      vy_r    <= view_origin_y;
      fslot_r <= fill_slot;
      fok_r   <= fill_ok;
    end
  end

  // tile range of the view; rows clamp to the world
  always_comb begin
    xe     = {vx_r[ORG_W-1], vx_r} + (ORG_W+1)'(VIEW_WIDTH - 1);
    ye     = {vy_r[ORG_W-1], vy_r} + (ORG_W+1)'(VIEW_HEIGHT - 1);
    tx0_w  = {vx_r[ORG_W-1], vx_r[ORG_W-1:TILE_SHIFT]};
    ty0_w  = {vy_r[ORG_W-1], vy_r[ORG_W-1:TILE_SHIFT]};
    tx1_w  = xe[ORG_W:TILE_SHIFT];
    ty1_w  = ye[ORG_W:TILE_SHIFT];
    mask_w = TILE_W'(((TILE_W+1)'(1) << zoom_r) - (TILE_W+1)'(1));
    ty0_s  = (TILE_W+1)'($signed(ty0_w));
    ty1_s  = (TILE_W+1)'($signed(ty1_w));
    mask_s = $signed({1'b0, mask_w});
    row_first = (ty0_s < 0) ? '0 : ty0_s;
    row_last  = (ty1_s > mask_s) ? mask_s : ty1_s;
  end

  // current tile geometry
  always_comb begin
    col_w    = (tx0_q + TILE_W'(coff_q)) & mask_q;
    dx       = DX_W'({coff_q, {TILE_SHIFT{1'b0}}}) - DX_W'(xoff_q);
    dy       = DY_W'({roff_q, {TILE_SHIFT{1'b0}}}) - DY_W'(yoff_q);
    sxb      = dx[DX_W-1] ? SRC_W'(DX_W'(0) - dx) : '0;
    syb      = dy[DY_W-1] ? SRC_W'(DY_W'(0) - dy) : '0;
    sxe      = ($signed(dx) > $signed(DX_W'(VIEW_WIDTH - TILE_EDGE))) ?
               SRC_W'(DX_W'(VIEW_WIDTH) - dx) : SRC_W'(TILE_EDGE);
    sye      = ($signed(dy) > $signed(DY_W'(VIEW_HEIGHT - TILE_EDGE))) ?
               SRC_W'(DY_W'(VIEW_HEIGHT) - dy) : SRC_W'(TILE_EDGE);
    col_wrap = (coff_q == ncol_m1_q);
    last_w   = col_wrap && (row_q == row_end_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      tx0_q     <= TILE_W'($signed(tx0_w));
      mask_q    <= mask_w;
      row_q     <= row_first[TILE_W-1:0];
      row_end_q <= row_last[TILE_W-1:0];
      roff_q    <= RIDX_W'(row_first - ty0_s);
      coff_q    <= '0;
      ncol_m1_q <= CIDX_W'(tx1_w - tx0_w);
      xoff_q    <= vx_r[TILE_SHIFT-1:0];
      yoff_q    <= vy_r[TILE_SHIFT-1:0];
    end else if (cmd.emit) begin
      if (col_wrap) begin
        coff_q <= '0;
        row_q  <= row_q + 1'b1;
        roff_q <= roff_q + 1'b1;
      end else begin
        coff_q <= coff_q + 1'b1;
      end
    end
  end

  always_comb begin
    req.lookup    = cmd.emit;
    req.fill      = cmd.fill;
    req.clear     = cmd.clear;
    req.fill_slot = fslot_r;
    req.fill_ok   = fok_r;
    req.zoom      = zoom_r;
    req.col       = col_w;
    req.row       = row_q;
  end

  mtwp_tags u_tags (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .status (tag_status),
    .slot   (tag_slot)
  );

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tile_col      <= col_w;
      tile_row      <= row_q;
      screen_x      <= dx[SX_W-1:0];
      screen_y      <= dy[SY_W-1:0];
      src_x_begin   <= sxb;
      src_y_begin   <= syb;
      src_x_end     <= sxe;
      src_y_end     <= sye;
      lookup_status <= tag_status;
      slot          <= tag_slot;
      last_tile     <= last_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.is_plan  = (mode_r == MODE_PLAN);
    sts.is_fill  = (mode_r == MODE_FILL);
    sts.is_clear = (mode_r == MODE_CLEAR);
    sts.has_tile = (row_first <= row_last);
    sts.last     = last_w;
    sts.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

[src/mtwp_ctrl.sv]
// Controller state machine: accepts items, sequences setup, store updates and tile walk.
// Depends on mtwp_pkg.
`default_nettype none
module mtwp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mtwp_pkg::dp_sts_t   sts,
  output mtwp_pkg::ctrl_cmd_t      cmd
);
  import mtwp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_WALK   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        if (sts.is_plan) begin
          cmd.setup = 1'b1;
          if (sts.has_tile) begin
            state_next = ST_WALK;
          end
        end else if (sts.is_fill) begin
          cmd.fill = 1'b1;
        end else if (sts.is_clear) begin
          cmd.clear = 1'b1;
        end
      end
      ST_WALK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[src/map_tile_window_planner_top.sv]
// Top level of the map tile window planner: controller plus datapath.
// Depends on mtwp_pkg, mtwp_ctrl, mtwp_dp (which holds mtwp_tags).
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_ready | mode, zoom, view_origin_x/y, fill_slot, fill_ok
//   out     | out_valid/out_ready | tile_col/row, screen_x/y, src_*, lookup_status,
//           |                     | slot, last_tile
//
// A plan item is accepted in IDLE and set up in DECODE, then walks one tile per cycle
// while the out channel is free (0 to 6 tiles), the tag compare and output register
// keeping pace. Fill, invalidate and reserved items are accepted and end in DECODE.
// Reset clears the FSM, the valid and pending bits and the replace pointer at once.
// A stalled out channel holds the walk; the next item is taken while a result waits.
`default_nettype none
module map_tile_window_planner_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [mtwp_pkg::MODE_W-1:0]         mode,
  input  wire logic [mtwp_pkg::ZOOM_W-1:0]         zoom,
  input  wire logic signed [mtwp_pkg::ORG_W-1:0]   view_origin_x,
  input  wire logic signed [mtwp_pkg::ORG_W-1:0]   view_origin_y,
  input  wire logic [mtwp_pkg::SLOT_W-1:0]         fill_slot,
  input  wire logic                                fill_ok,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [mtwp_pkg::TILE_W-1:0]              tile_col,
  output logic [mtwp_pkg::TILE_W-1:0]              tile_row,
  output logic signed [mtwp_pkg::SX_W-1:0]         screen_x,
  output logic signed [mtwp_pkg::SY_W-1:0]         screen_y,
  output logic [mtwp_pkg::SRC_W-1:0]               src_x_begin,
  output logic [mtwp_pkg::SRC_W-1:0]               src_y_begin,
  output logic [mtwp_pkg::SRC_W-1:0]               src_x_end,
  output logic [mtwp_pkg::SRC_W-1:0]               src_y_end,
  output logic [mtwp_pkg::ST_W-1:0]                lookup_status,
  output logic [mtwp_pkg::SLOT_W-1:0]              slot,
  output logic                                     last_tile
);
  import mtwp_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  mtwp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtwp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .zoom          (zoom),
    .view_origin_x (view_origin_x),
    .view_origin_y (view_origin_y),
    .fill_slot     (fill_slot),
    .fill_ok       (fill_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tile_col      (tile_col),
    .tile_row      (tile_row),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .src_x_begin   (src_x_begin),
    .src_y_begin   (src_y_begin),
    .src_x_end     (src_x_end),
    .src_y_end     (src_y_end),
    .lookup_status (lookup_status),
    .slot          (slot),
    .last_tile     (last_tile)
  );

endmodule
`default_nettype wire

[src/mtwp_checker.sv]
// Port-level checker for the map tile window planner, bound to the top level.
// Depends on mtwp_pkg and map_tile_window_planner_top.
`default_nettype none
module mtwp_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [mtwp_pkg::TILE_W-1:0]         tile_col,
  input wire logic [mtwp_pkg::TILE_W-1:0]         tile_row,
  input wire logic signed [mtwp_pkg::SX_W-1:0]    screen_x,
  input wire logic signed [mtwp_pkg::SY_W-1:0]    screen_y,
  input wire logic [mtwp_pkg::SRC_W-1:0]          src_x_begin,
  input wire logic [mtwp_pkg::SRC_W-1:0]          src_y_begin,
  input wire logic [mtwp_pkg::SRC_W-1:0]          src_x_end,
  input wire logic [mtwp_pkg::SRC_W-1:0]          src_y_end,
  input wire logic [mtwp_pkg::ST_W-1:0]           lookup_status,
  input wire logic [mtwp_pkg::SLOT_W-1:0]         slot,
  input wire logic                                last_tile
);
  import mtwp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(tile_col) && $stable(tile_row) &&
      $stable(screen_x) && $stable(screen_y) && $stable(lookup_status) &&
      $stable(slot) && $stable(last_tile))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lookup_status == LK_HIT || lookup_status == LK_MISS ||
      lookup_status == LK_PEND)
    else $error("bad lookup status");

  a_clip_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> src_x_begin < src_x_end && src_y_begin < src_y_end)
    else $error("empty clip rectangle");

  a_clip_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (screen_x < 0) == (src_x_begin != '0) &&
      (screen_y < 0) == (src_y_begin != '0))
    else $error("clip start disagrees with screen offset");

endmodule

bind map_tile_window_planner_top mtwp_checker u_mtwp_checker (.*);
`default_nettype wire
